[design/vpbe_pkg.sv]
// Shared types, byte codes and number-code helpers for the vector path byte encoder.
// No dependencies; every other file refers to it by scoped names.
package vpbe_pkg;

   localparam int IN_W      = 24;
   localparam int SCALE_W   = 16;
   localparam int MAG_BITS  = 22;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [MAG_BITS-1:0] MAG_MAX  = {MAG_BITS{1'b1}};
   localparam logic [MAG_BITS-1:0] DIG1_MIN = MAG_BITS'('h10);
   localparam logic [MAG_BITS-1:0] DIG2_MIN = MAG_BITS'('h400);
   localparam logic [MAG_BITS-1:0] DIG3_MIN = MAG_BITS'('h10000);

   localparam logic signed [MAG_BITS+1:0] D_MAX = {2'b00, MAG_MAX};
   localparam logic signed [MAG_BITS+1:0] D_MIN = -D_MAX;

   localparam logic [7:0] TAG_DIGIT   = 8'h40;
   localparam logic [7:0] SIGN_POS    = 8'h30;
   localparam logic [7:0] SIGN_NEG    = 8'h20;
   localparam logic [7:0] OP_POLYLINE = 8'h31;
   localparam logic [7:0] OP_POLYGON  = 8'h32;
   localparam logic [7:0] OP_END      = 8'h1e;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd25600;

   localparam logic [CSR_IDX_W-1:0] CSR_PEN_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Q15   = 2'd1;

   typedef enum logic [1:0] {
      CMD_MOVE,
      CMD_DRAW,
      CMD_PATH_FIRST,
      CMD_PATH_NEXT
   } cmd_type;

   typedef struct packed {
      logic               pen_enabled;
      logic [SCALE_W-1:0] scale;
   } cfg_type;

   // One coded number: sign, magnitude and index of its leading digit.
   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
      logic [1:0]          top;
   } num_type;

   typedef struct packed {
      logic           has_head;
      logic [7:0]     head;
      logic           num_four;
      logic           has_tail;
      num_type [3:0]  nums;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic busy;
   } back_stat_type;

   function automatic logic [1:0] num_top(input logic [MAG_BITS-1:0] m);
      logic [1:0] t;
      if (m >= DIG3_MIN) t = 2'd3;
      else if (m >= DIG2_MIN) t = 2'd2;
      else if (m >= DIG1_MIN) t = 2'd1;
      else t = 2'd0;
      return t;
   endfunction

   function automatic num_type to_num(input logic signed [MAG_BITS:0] v);
      num_type        n;
      logic [MAG_BITS:0] a;
      a     = v[MAG_BITS] ? -v : v;
      n.neg = v[MAG_BITS];
      n.mag = a[MAG_BITS-1:0];
      n.top = num_top(a[MAG_BITS-1:0]);
      return n;
   endfunction

   function automatic logic signed [MAG_BITS:0] sat_delta(input logic signed [MAG_BITS+1:0] d);
      logic signed [MAG_BITS+1:0] r;
      if (d > D_MAX) r = D_MAX;
      else if (d < D_MIN) r = D_MIN;
      else r = d;
      return r[MAG_BITS:0];
   endfunction

endpackage

[design/vpbe_if.sv]
// Channel interfaces of the vector path byte encoder: point input, byte output, register writes.
// Depends on vpbe_pkg for field widths.
interface vpbe_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      cmd;
   logic signed [vpbe_pkg::IN_W-1:0] coord_x;
   logic signed [vpbe_pkg::IN_W-1:0] coord_y;
   logic                            is_polygon;
   logic                            path_end;
   modport source (output valid, cmd, coord_x, coord_y, is_polygon, path_end, input ready);
   modport sink   (input valid, cmd, coord_x, coord_y, is_polygon, path_end, output ready);
endinterface

interface vpbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, out_byte, out_last, input ready);
   modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface vpbe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [vpbe_pkg::CSR_IDX_W-1:0]    index;
   logic [vpbe_pkg::CSR_DAT_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/vpbe_front.sv]
// Front end: accepts points, scales them, tracks the pen position and builds queue entries.
// Depends on vpbe_pkg and vpbe_req_if.
module vpbe_front #(
   parameter int SCALE_FRAC_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vpbe_pkg::cfg_type     cfg,
   vpbe_req_if.sink              req,
   output logic                  q_push,
   output vpbe_pkg::q_entry_type q_data,
   input  vpbe_pkg::q_stat_type  q_stat
);

   localparam int IN_W   = vpbe_pkg::IN_W;
   localparam int MB     = vpbe_pkg::MAG_BITS;
   localparam int PROD_W = vpbe_pkg::IN_W + vpbe_pkg::SCALE_W;

   typedef struct packed {
      vpbe_pkg::cmd_type cmd;
      logic              poly;
      logic              last;
   } ctrl_type;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   ctrl_type          s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff, s1_ctrl_in;
   logic              s1_neg_x_ff, s1_neg_y_ff, s2_neg_x_ff, s2_neg_y_ff;
   logic [IN_W-1:0]   s1_mag_x_ff, s1_mag_y_ff, s1_mag_x_in, s1_mag_y_in;
   logic [PROD_W-1:0] s2_prod_x_ff, s2_prod_y_ff, s2_prod_x_in, s2_prod_y_in;
   logic signed [MB:0] s3_val_x_ff, s3_val_y_ff, s3_val_x_in, s3_val_y_in;
   logic signed [MB:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [MB+1:0] dx, dy;
   logic              push_want, adv;

   function automatic logic signed [MB:0] scale_out(input logic [PROD_W-1:0] p,
                                                     input logic neg);
      logic [PROD_W-1:0] sh;
      logic [MB:0]       m;
      sh = p >> SCALE_FRAC_BITS;
      m  = (|sh[PROD_W-1:MB]) ? {1'b0, vpbe_pkg::MAG_MAX} : {1'b0, sh[MB-1:0]};
      return neg ? -m : m;
   endfunction

   // stall the whole pipe only when stage 3 has bytes and the queue is full
   assign push_want = s3_valid_ff && cfg.pen_enabled && (s3_ctrl_ff.cmd != vpbe_pkg::CMD_MOVE);
   assign adv       = !(push_want && q_stat.full);
   assign q_push    = push_want && !q_stat.full;
   assign req.ready = adv;

   always_comb begin
      s1_ctrl_in.cmd  = vpbe_pkg::cmd_type'(req.cmd);
      s1_ctrl_in.poly = req.is_polygon;
      s1_ctrl_in.last = req.path_end;
      s1_mag_x_in     = req.coord_x[IN_W-1] ? IN_W'(-req.coord_x) : IN_W'(req.coord_x);
      s1_mag_y_in     = req.coord_y[IN_W-1] ? IN_W'(-req.coord_y) : IN_W'(req.coord_y);
      s2_prod_x_in    = PROD_W'(s1_mag_x_ff) * PROD_W'(cfg.scale);
      s2_prod_y_in    = PROD_W'(s1_mag_y_ff) * PROD_W'(cfg.scale);
      s3_val_x_in     = scale_out(s2_prod_x_ff, s2_neg_x_ff);
      s3_val_y_in     = scale_out(s2_prod_y_ff, s2_neg_y_ff);
   end

   always_comb begin
      dx = {s3_val_x_ff[MB], s3_val_x_ff} - {pos_x_ff[MB], pos_x_ff};
      dy = {s3_val_y_ff[MB], s3_val_y_ff} - {pos_y_ff[MB], pos_y_ff};

      // a path point after the first with the pen up keeps the old position
      if ((s3_ctrl_ff.cmd == vpbe_pkg::CMD_PATH_NEXT) && !cfg.pen_enabled) begin
         pos_x_in = pos_x_ff;
         pos_y_in = pos_y_ff;
      end else begin
         pos_x_in = s3_val_x_ff;
         pos_y_in = s3_val_y_ff;
      end

      q_data.has_head = 1'b0;
      q_data.head     = vpbe_pkg::OP_POLYLINE;
      q_data.num_four = 1'b0;
      q_data.has_tail = s3_ctrl_ff.last;
      q_data.nums[0]  = vpbe_pkg::to_num(vpbe_pkg::sat_delta(dx));
      q_data.nums[1]  = vpbe_pkg::to_num(vpbe_pkg::sat_delta(dy));
      q_data.nums[2]  = vpbe_pkg::to_num(vpbe_pkg::sat_delta(dx));
      q_data.nums[3]  = vpbe_pkg::to_num(vpbe_pkg::sat_delta(dy));
      unique case (s3_ctrl_ff.cmd)
         vpbe_pkg::CMD_MOVE: begin
            q_data.has_tail = 1'b0;
         end
         vpbe_pkg::CMD_DRAW: begin
            q_data.has_head = 1'b1;
            q_data.num_four = 1'b1;
            q_data.has_tail = 1'b1;
            q_data.nums[0]  = vpbe_pkg::to_num(pos_x_ff);
            q_data.nums[1]  = vpbe_pkg::to_num(pos_y_ff);
         end
         vpbe_pkg::CMD_PATH_FIRST: begin
            q_data.has_head = 1'b1;
            q_data.head     = s3_ctrl_ff.poly ? vpbe_pkg::OP_POLYGON : vpbe_pkg::OP_POLYLINE;
            q_data.nums[0]  = vpbe_pkg::to_num(s3_val_x_ff);
            q_data.nums[1]  = vpbe_pkg::to_num(s3_val_y_ff);
         end
         vpbe_pkg::CMD_PATH_NEXT: begin
            q_data.has_head = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
      end else if (adv) begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctrl_ff   <= s1_ctrl_in;
         s1_neg_x_ff  <= req.coord_x[IN_W-1];
         s1_neg_y_ff  <= req.coord_y[IN_W-1];
         s1_mag_x_ff  <= s1_mag_x_in;
         s1_mag_y_ff  <= s1_mag_y_in;
         s2_ctrl_ff   <= s1_ctrl_ff;
         s2_neg_x_ff  <= s1_neg_x_ff;
         s2_neg_y_ff  <= s1_neg_y_ff;
         s2_prod_x_ff <= s2_prod_x_in;
         s2_prod_y_ff <= s2_prod_y_in;
         s3_ctrl_ff   <= s2_ctrl_ff;
         s3_val_x_ff  <= s3_val_x_in;
         s3_val_y_ff  <= s3_val_y_in;
      end
   end

endmodule

[design/vpbe_queue.sv]
// Short entry queue between front end and byte serializer.
// Depends on vpbe_pkg for the entry type and depth.
module vpbe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vpbe_pkg::q_entry_type push_data,
   input  logic                  pop,
   output vpbe_pkg::q_entry_type pop_data,
   output vpbe_pkg::q_stat_type  stat
);

   vpbe_pkg::q_entry_type            entry_ff [vpbe_pkg::Q_DEPTH];
   logic [vpbe_pkg::Q_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [vpbe_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == vpbe_pkg::Q_CNT_W'(vpbe_pkg::Q_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[design/vpbe_back.sv]
// Back end: walks one queue entry and sends its command bytes one word per cycle while the
// output is ready. Depends on vpbe_pkg and vpbe_rsp_if.
module vpbe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  vpbe_pkg::q_entry_type    q_data,
   input  vpbe_pkg::q_stat_type     q_stat,
   output logic                     q_pop,
   vpbe_rsp_if.source               rsp,
   output vpbe_pkg::back_stat_type  stat
);

   typedef enum logic [1:0] {SEG_HEAD, SEG_NUM, SEG_TAIL} seg_type;

   seg_type               seg_ff, seg_in;
   logic                  busy_ff;
   vpbe_pkg::q_entry_type cur_ff;
   logic [1:0]            idx_ff, idx_in, dig_ff, dig_in, rem;
   logic                  rsp_valid_ff, rsp_last_ff, done_in;
   logic [7:0]            rsp_byte_ff, byte_in;
   vpbe_pkg::num_type     num;
   logic                  step, last_num;

   assign step        = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign q_pop       = !q_stat.empty && (!busy_ff || (step && done_in));
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.out_last = rsp_last_ff;
   assign stat.busy   = busy_ff;

   always_comb begin
      num      = cur_ff.nums[idx_ff];
      rem      = num.top - dig_ff;
      last_num = (idx_ff == (cur_ff.num_four ? 2'd3 : 2'd1));
      seg_in   = seg_ff;
      idx_in   = idx_ff;
      dig_in   = dig_ff;
      done_in  = 1'b0;
      byte_in  = vpbe_pkg::OP_END;
      unique case (seg_ff)
         SEG_HEAD: begin
            byte_in = cur_ff.head;
            seg_in  = SEG_NUM;
            idx_in  = 2'd0;
            dig_in  = 2'd0;
         end
         SEG_NUM: begin
            case (rem)
               2'd0: byte_in = (num.neg ? vpbe_pkg::SIGN_NEG : vpbe_pkg::SIGN_POS)
                               | {4'h0, num.mag[3:0]};
               2'd1: byte_in = vpbe_pkg::TAG_DIGIT | {2'b00, num.mag[9:4]};
               2'd2: byte_in = vpbe_pkg::TAG_DIGIT | {2'b00, num.mag[15:10]};
               default: byte_in = vpbe_pkg::TAG_DIGIT | {2'b00, num.mag[21:16]};
            endcase
            if (rem == 2'd0) begin
               dig_in = 2'd0;
               if (last_num) begin
                  seg_in  = SEG_TAIL;
                  done_in = !cur_ff.has_tail;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else begin
               dig_in = dig_ff + 2'd1;
            end
         end
         SEG_TAIL: begin
            byte_in = vpbe_pkg::OP_END;
            done_in = 1'b1;
         end
         default: begin
            done_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seg_ff       <= SEG_HEAD;
         idx_ff       <= 2'd0;
         dig_ff       <= 2'd0;
      end else begin
         if (step) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_ff  <= byte_in;
            rsp_last_ff  <= done_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // load the next entry, possibly right behind the last byte of this one
         if (q_pop) begin
            cur_ff  <= q_data;
            busy_ff <= 1'b1;
            seg_ff  <= q_data.has_head ? SEG_HEAD : SEG_NUM;
            idx_ff  <= 2'd0;
            dig_ff  <= 2'd0;
         end else begin
            if (step) begin
               seg_ff <= seg_in;
               idx_ff <= idx_in;
               dig_ff <= dig_in;
            end
            if (step && done_in) busy_ff <= 1'b0;
         end
      end
   end

endmodule

[design/vector_path_byte_encoder_top.sv]
// Top level of the vector path byte encoder: registers, front end, queue and byte serializer.
// Depends on vpbe_pkg, vpbe_if, vpbe_front, vpbe_queue and vpbe_back.
//
//   channel   dir   word                                          handshake
//   req_ch    in    cmd, coord_x, coord_y, is_polygon, path_end   valid/ready
//   rsp_ch    out   out_byte, out_last                            valid/ready
//   csr_ch    in    index, data                                   valid/ready (ready held high)
//
// The front end takes one point per cycle unless stalled, via stages s1, s2, s3. The serializer
// sends one byte per cycle while the output is ready, 2 to 18 bytes per point (a draw needs
// up to 18), so the byte-wide output sets the sustained rate; moves and pen-up points take
// no output time. Reset is synchronous: pen off, scale 25600, position zero, queue and output
// empty. A stalled output fills the two-entry queue, then the front end holds and drops ready.
module vector_path_byte_encoder_top #(
   parameter int SCALE_FRAC_BITS = 15
) (
   input  logic       clock,
   input  logic       reset,
   vpbe_req_if.sink   req_ch,
   vpbe_rsp_if.source rsp_ch,
   vpbe_csr_if.sink   csr_ch
);

   vpbe_pkg::cfg_type       cfg_ff;
   vpbe_pkg::q_entry_type   q_push_data, q_pop_data;
   vpbe_pkg::q_stat_type    q_stat;
   vpbe_pkg::back_stat_type b_stat;
   logic                    q_push, q_pop;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pen_enabled <= 1'b0;
         cfg_ff.scale       <= vpbe_pkg::SCALE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            vpbe_pkg::CSR_PEN_ENABLED: cfg_ff.pen_enabled <= csr_ch.data[0];
            vpbe_pkg::CSR_SCALE_Q15:   cfg_ff.scale       <= csr_ch.data;
            default: ;
         endcase
      end
   end

   vpbe_front #(
      .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_ch),
      .q_push (q_push),
      .q_data (q_push_data),
      .q_stat (q_stat)
   );

   vpbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   vpbe_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_data (q_pop_data),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .rsp    (rsp_ch),
      .stat   (b_stat)
   );

   a_q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue push while full");

   a_q_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue pop while empty");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.out_last && q_stat.empty && !b_stat.busy)
      |=> !rsp_ch.valid)
      else $error("output word appeared with no work pending");

endmodule

[tb/sv/tb_top.sv]
// Testbench for vector_path_byte_encoder_top: random and directed plotter points in, command bytes out.
// Uses vpbe_pkg and the channel interfaces of vpbe_if; the expected byte stream
// is computed by the vector_stream_book class below.
module tb_top;

   localparam int MAG_BITS      = vpbe_pkg::MAG_BITS;
   localparam int IN_W          = vpbe_pkg::IN_W;
   localparam int SCALE_W       = vpbe_pkg::SCALE_W;
   localparam int CSR_IDX_W     = vpbe_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W     = vpbe_pkg::CSR_DAT_W;
   localparam int SCALE_FRAC    = 15;
   localparam int MAG_LIM       = (1 << MAG_BITS) - 1;
   localparam int PROD_W        = IN_W + SCALE_W;
   localparam int IDLE_PCT      = 22;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int TAIL_CYCLES   = 30;
   localparam int PHASE_ITEMS   = 40;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      vpbe_pkg::cmd_type      cmd;
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic                   poly;
      logic                   pend;
   } point_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } stream_byte_type;

   // Tracks pen position and registers, and holds the bytes still owed by the block.
   class vector_stream_book;
      logic                     pen;
      logic [SCALE_W-1:0]       scale;
      logic signed [MAG_BITS:0] px;
      logic signed [MAG_BITS:0] py;
      logic [7:0]               staged[$];
      stream_byte_type          expected_bytes[$];
      int                       errors;
      int                       seen;

      function new();
         pen    = 1'b0;
         scale  = vpbe_pkg::SCALE_RESET;
         px     = '0;
         py     = '0;
         errors = 0;
         seen   = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
         if (idx == vpbe_pkg::CSR_PEN_ENABLED) pen = data[0];
         else if (idx == vpbe_pkg::CSR_SCALE_Q15) scale = data[SCALE_W-1:0];
      endfunction

      function bit busy();
         return expected_bytes.size() != 0;
      endfunction

      // Scale by magnitude, truncate toward zero, clamp, then restore the sign.
      function logic signed [MAG_BITS:0] scaled(input logic signed [IN_W-1:0] c);
         logic [IN_W-1:0]          mag;
         logic [PROD_W-1:0]        prod;
         logic signed [MAG_BITS:0] r;
         mag  = c[IN_W-1] ? -c : c;
         prod = (PROD_W'(mag) * PROD_W'(scale)) >> SCALE_FRAC;
         if (prod > MAG_LIM) prod = PROD_W'(MAG_LIM);
         r = (MAG_BITS+1)'(prod);
         return c[IN_W-1] ? -r : r;
      endfunction

      function void push_num(input logic signed [MAG_BITS+1:0] v);
         logic [MAG_BITS-1:0] m;
         logic                neg;
         if (v > MAG_LIM) v = (MAG_BITS+2)'(MAG_LIM);
         else if (v < -MAG_LIM) v = -(MAG_BITS+2)'(MAG_LIM);
         neg = v < 0;
         m   = MAG_BITS'(neg ? -v : v);
         if (m >= vpbe_pkg::DIG3_MIN)
            staged.push_back(vpbe_pkg::TAG_DIGIT | 8'(m >> 16));
         if (m >= vpbe_pkg::DIG2_MIN)
            staged.push_back(vpbe_pkg::TAG_DIGIT | 8'((m & 22'hffff) >> 10));
         if (m >= vpbe_pkg::DIG1_MIN)
            staged.push_back(vpbe_pkg::TAG_DIGIT | 8'((m & 22'h3ff) >> 4));
         staged.push_back((neg ? vpbe_pkg::SIGN_NEG : vpbe_pkg::SIGN_POS) | 8'(m & 22'hf));
      endfunction

      function void take_point(input point_type p);
         logic signed [MAG_BITS:0]   nx;
         logic signed [MAG_BITS:0]   ny;
         logic signed [MAG_BITS+1:0] dx;
         logic signed [MAG_BITS+1:0] dy;
         nx = scaled(p.x);
         ny = scaled(p.y);
         dx = nx - px;
         dy = ny - py;
         staged.delete();
         case (p.cmd)
            vpbe_pkg::CMD_MOVE: ;
            vpbe_pkg::CMD_DRAW: begin
               if (pen) begin
                  staged.push_back(vpbe_pkg::OP_POLYLINE);
                  push_num(px);
                  push_num(py);
                  push_num(dx);
                  push_num(dy);
                  staged.push_back(vpbe_pkg::OP_END);
               end
            end
            vpbe_pkg::CMD_PATH_FIRST: begin
               if (pen) begin
                  staged.push_back(p.poly ? vpbe_pkg::OP_POLYGON : vpbe_pkg::OP_POLYLINE);
                  push_num(nx);
                  push_num(ny);
                  if (p.pend) staged.push_back(vpbe_pkg::OP_END);
               end
            end
            default: begin
               if (pen) begin
                  push_num(dx);
                  push_num(dy);
                  if (p.pend) staged.push_back(vpbe_pkg::OP_END);
               end else begin
                  // pen up: a path point keeps the old position
                  nx = px;
                  ny = py;
               end
            end
         endcase
         px = nx;
         py = ny;
         foreach (staged[i])
            expected_bytes.push_back(stream_byte_type'{staged[i], i == staged.size() - 1});
      endfunction

      task report(input string what);
         errors++;
         $display("byte %0d: %s", seen, what);
      endtask

      task match_byte(input logic [7:0] b, input logic l);
         stream_byte_type e;
         seen++;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", b, l));
            return;
         end
         e = expected_bytes.pop_front();
         if (b !== e.value) report($sformatf("out_byte %02h, want %02h", b, e.value));
         if (l !== e.last) report($sformatf("out_last %0b, want %0b", l, e.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   calm = 1'b0;
   bit   hold_request = 1'b0;

   vector_stream_book stream = new();

   vpbe_req_if req_ch();
   vpbe_rsp_if rsp_ch();
   vpbe_csr_if csr_ch();

   vector_path_byte_encoder_top #(.SCALE_FRAC_BITS(SCALE_FRAC)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic point_type pt(vpbe_pkg::cmd_type c, int x, int y, bit poly, bit pend);
      point_type p;
      p.cmd  = c;
      p.x    = IN_W'(x);
      p.y    = IN_W'(y);
      p.poly = poly;
      p.pend = pend;
      return p;
   endfunction

   function automatic bit coin();
      return 1'($urandom_range(1));
   endfunction

   function automatic logic signed [IN_W-1:0] rand_coord();
      logic [IN_W-1:0] mag;
      case ($urandom_range(5))
         0: mag = IN_W'($urandom_range(15));
         1: mag = IN_W'($urandom_range(1023, 16));
         2: mag = IN_W'($urandom_range(65535, 1024));
         3: mag = IN_W'($urandom_range(8388607, 65536));
         4: begin
            case ($urandom_range(3))
               0: return 24'sh7fffff;
               1: return 24'sh800000;
               2: return 24'sh000000;
               default: return 24'shffffff;
            endcase
         end
         default: return IN_W'($urandom());
      endcase
      return coin() ? -mag : mag;
   endfunction

   task automatic send_point(input point_type p);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= p.cmd;
      req_ch.coord_x    <= p.x;
      req_ch.coord_y    <= p.y;
      req_ch.is_polygon <= p.poly;
      req_ch.path_end   <= p.pend;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      stream.take_point(p);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      stream.set_reg(idx, data);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for the last byte, then let pen-up work finish inside the block.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (stream.busy()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int n);
      int done;
      int k;
      bit poly;
      done = 0;
      while (done < n) begin
         case ($urandom_range(9))
            0, 1: begin
               send_point(pt(vpbe_pkg::CMD_MOVE, rand_coord(), rand_coord(), coin(), coin()));
               done++;
            end
            2, 3, 4: begin
               send_point(pt(vpbe_pkg::CMD_DRAW, rand_coord(), rand_coord(), coin(), coin()));
               done++;
            end
            5, 6, 7, 8: begin
               poly = coin();
               k    = $urandom_range(4);
               send_point(pt(vpbe_pkg::CMD_PATH_FIRST, rand_coord(), rand_coord(), poly,
                             k == 0));
               for (int i = 1; i <= k; i++)
                  send_point(pt(vpbe_pkg::CMD_PATH_NEXT, rand_coord(), rand_coord(), coin(),
                                i == k));
               done += k + 1;
            end
            default: begin
               // broken sequences: any command, any flags
               send_point(pt(vpbe_pkg::cmd_type'($urandom_range(3)), rand_coord(), rand_coord(),
                             coin(), coin()));
               done++;
            end
         endcase
      end
   endtask

   initial begin : drain_bytes
      int hold_left;
      bit hold_taken;
      hold_left    = 0;
      hold_taken   = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) stream.match_byte(rsp_ch.out_byte, rsp_ch.out_last);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      req_ch.valid      = 1'b0;
      req_ch.cmd        = vpbe_pkg::CMD_MOVE;
      req_ch.coord_x    = '0;
      req_ch.coord_y    = '0;
      req_ch.is_polygon = 1'b0;
      req_ch.path_end   = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = vpbe_pkg::CSR_PEN_ENABLED;
      csr_ch.data       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pen is off after reset: position moves, nothing is sent
      send_point(pt(vpbe_pkg::CMD_MOVE, 1000, 2000, 0, 0));
      send_point(pt(vpbe_pkg::CMD_DRAW, 3000, -4000, 0, 0));
      send_point(pt(vpbe_pkg::CMD_PATH_FIRST, -5000, 6000, 1, 1));
      send_point(pt(vpbe_pkg::CMD_PATH_NEXT, 77, 88, 0, 1));
      settle();

      write_reg(vpbe_pkg::CSR_PEN_ENABLED, 16'h0001);
      write_reg(vpbe_pkg::CSR_SCALE_Q15, 16'h8000);
      send_point(pt(vpbe_pkg::CMD_DRAW, 0, 0, 0, 0));
      send_point(pt(vpbe_pkg::CMD_MOVE, 0, 0, 0, 0));
      send_point(pt(vpbe_pkg::CMD_DRAW, 15, -16, 0, 0));
      send_point(pt(vpbe_pkg::CMD_DRAW, 1023, 1024, 0, 0));
      send_point(pt(vpbe_pkg::CMD_DRAW, 65535, -65536, 0, 0));
      send_point(pt(vpbe_pkg::CMD_MOVE, 8388607, -8388608, 1, 1));
      send_point(pt(vpbe_pkg::CMD_DRAW, -8388608, 8388607, 0, 1));
      send_point(pt(vpbe_pkg::CMD_PATH_FIRST, 100, -200, 0, 0));
      send_point(pt(vpbe_pkg::CMD_PATH_NEXT, 65536, 5, 1, 0));
      send_point(pt(vpbe_pkg::CMD_PATH_NEXT, -5, 1023, 0, 1));
      send_point(pt(vpbe_pkg::CMD_PATH_FIRST, 7, 7, 1, 1));
      send_point(pt(vpbe_pkg::CMD_PATH_NEXT, -1, -1, 0, 0));
      send_point(pt(vpbe_pkg::CMD_PATH_NEXT, 8388607, 8388607, 0, 1));
      send_point(pt(vpbe_pkg::CMD_DRAW, 1024, 1023, 1, 0));
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(vpbe_pkg::CSR_SCALE_Q15, vpbe_pkg::SCALE_RESET);
               hold_request = 1'b1;
            end
            1: begin
               write_reg(vpbe_pkg::CSR_SCALE_Q15, 16'hffff);
               calm = 1'b1;
            end
            2: begin
               write_reg(vpbe_pkg::CSR_SCALE_Q15, 16'h0001);
               calm = 1'b0;
            end
            3: write_reg(vpbe_pkg::CSR_SCALE_Q15, 16'h0000);
            4: begin
               write_reg(vpbe_pkg::CSR_PEN_ENABLED, {15'($urandom()), 1'b0});
               write_reg(vpbe_pkg::CSR_SCALE_Q15, 16'($urandom()));
               write_reg(CSR_SPARE, 16'($urandom()));
            end
            default: begin
               write_reg(vpbe_pkg::CSR_PEN_ENABLED, {15'($urandom()), 1'b1});
               write_reg(vpbe_pkg::CSR_SCALE_Q15, 16'($urandom()));
            end
         endcase
         run_random(PHASE_ITEMS);
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (stream.errors == 0 && !stream.busy())
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
